// ===== rtl/ard_pkg.sv =====
// ----------------------------------------------------------------------------
// ard_pkg: shared types and constants of the attitude report deframer
// Frame sync bytes, register map, queue sizing and the record that travels
// from the frame tracker to the angle stage.
// ----------------------------------------------------------------------------
package ard_pkg;

  localparam logic [7:0] SyncFirst   = 8'hA5;
  localparam logic [7:0] SyncSecond  = 8'h5A;
  localparam logic [7:0] CodeReset    = 8'h03;
  localparam logic [7:0] SubcodeReset = 8'h10;

  // Register indexes, taken from paddr[2].
  localparam logic RegCode    = 1'b0;
  localparam logic RegSubcode = 1'b1;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned AngleW = 17;

  // Frame positions that carry header and angle bytes.
  localparam logic [8:0] PosSync    = 9'd1;
  localparam logic [8:0] PosCode    = 9'd2;
  localparam logic [8:0] PosSubcode = 9'd3;
  localparam logic [8:0] PosLength  = 9'd4;
  localparam logic [8:0] PosPayload = 9'd5;
  localparam logic [8:0] PosPitchLo = 9'd6;
  localparam logic [8:0] PosPitchHi = 9'd7;
  localparam logic [8:0] PosRollLo  = 9'd8;
  localparam logic [8:0] PosRollHi  = 9'd9;
  localparam logic [8:0] PosYawLo   = 9'd10;
  localparam logic [8:0] PosYawHi   = 9'd11;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [7:0] pitch_lo;
    logic [7:0] pitch_hi;
    logic [7:0] roll_lo;
    logic [7:0] roll_hi;
    logic [7:0] yaw_lo;
    logic [7:0] yaw_hi;
  } ard_raw_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } ard_qstat_t;

  // High byte times 256, plus the low byte when that product is positive,
  // minus it otherwise; both bytes are two's complement.
  function automatic logic signed [AngleW-1:0] angle_of(logic [7:0] hi, logic [7:0] lo);
    logic signed [AngleW-1:0] base;
    logic signed [AngleW-1:0] low_ext;
    base    = {hi[7], hi, 8'h00};
    low_ext = {{(AngleW-8){lo[7]}}, lo};
    if (!hi[7] && (hi != 8'h00)) begin
      angle_of = base + low_ext;
    end else begin
      angle_of = base - low_ext;
    end
  endfunction

endpackage

// ===== rtl/ard_front.sv =====
// ----------------------------------------------------------------------------
// ard_front: frame tracker
// Follows the frame position byte by byte, keeps the header and the angle
// bytes, and issues a raw record when a matching report completes.
// ----------------------------------------------------------------------------
module ard_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        report_code_i,
  input  logic [7:0]        report_subcode_i,
  output logic              rec_valid_o,
  output ard_pkg::ard_raw_t rec_o
);
  import ard_pkg::*;

  logic [8:0] pos_q, pos_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] code_q, code_d;
  logic [7:0] sub_q, sub_d;
  ard_raw_t   raw_q, raw_d;

  always_comb begin
    pos_d       = pos_q;
    rem_d       = rem_q;
    code_d      = code_q;
    sub_d       = sub_q;
    raw_d       = raw_q;
    rec_valid_o = 1'b0;
    if (take_i) begin
      if (rx_byte_i == SyncFirst) begin
        pos_d = PosSync;
      end else if (rx_byte_i == SyncSecond && pos_q == PosSync) begin
        pos_d = PosCode;
      end else if (pos_q == PosCode) begin
        code_d = rx_byte_i;
        pos_d  = PosSubcode;
      end else if (pos_q == PosSubcode) begin
        sub_d = rx_byte_i;
        pos_d = PosLength;
      end else if (pos_q == PosLength) begin
        rem_d = rx_byte_i;
        pos_d = PosPayload;
      end else begin
        case (pos_q)
          PosPitchLo: raw_d.pitch_lo = rx_byte_i;
          PosPitchHi: raw_d.pitch_hi = rx_byte_i;
          PosRollLo:  raw_d.roll_lo  = rx_byte_i;
          PosRollHi:  raw_d.roll_hi  = rx_byte_i;
          PosYawLo:   raw_d.yaw_lo   = rx_byte_i;
          PosYawHi:   raw_d.yaw_hi   = rx_byte_i;
          default: ;
        endcase
        // Any other byte counts as payload, also when the second sync is missing.
        if (rem_q != 8'd0) begin
          rem_d = rem_q - 8'd1;
          pos_d = pos_q + 9'd1;
          if (rem_q == 8'd1 && code_q == report_code_i && sub_q == report_subcode_i) begin
            rec_valid_o = 1'b1;
          end
        end
      end
    end
  end

  // The record carries the bytes as they stand after this beat's capture.
  assign rec_o = raw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      rem_q  <= '0;
      code_q <= '0;
      sub_q  <= '0;
      raw_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      rem_q  <= rem_d;
      code_q <= code_d;
      sub_q  <= sub_d;
      raw_q  <= raw_d;
    end
  end

endmodule

// ===== rtl/ard_queue.sv =====
// ----------------------------------------------------------------------------
// ard_queue: record queue
// A short first-in first-out store of raw records between the frame tracker
// and the angle stage.
// ----------------------------------------------------------------------------
module ard_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  ard_pkg::ard_raw_t   wr_data_i,
  input  logic                rd_i,
  output ard_pkg::ard_raw_t   rd_data_o,
  output ard_pkg::ard_qstat_t stat_o
);
  import ard_pkg::*;

  ard_raw_t         mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;

  always_comb begin
    wptr_d = do_wr ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/ard_back.sv =====
// ----------------------------------------------------------------------------
// ard_back: angle stage
// Turns the oldest raw record into three angles and holds them in the
// output register until the result beat is taken.
// ----------------------------------------------------------------------------
module ard_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rec_avail_i,
  input  ard_pkg::ard_raw_t              rec_i,
  output logic                           rec_take_o,
  input  logic                           pop,
  output logic                           empty,
  output logic signed [ard_pkg::AngleW-1:0] yaw_centi_o,
  output logic signed [ard_pkg::AngleW-1:0] roll_centi_o,
  output logic signed [ard_pkg::AngleW-1:0] pitch_centi_o
);
  import ard_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [AngleW-1:0] yaw_q, roll_q, pitch_q;

  assign empty      = !valid_q;
  assign rec_take_o = rec_avail_i && (!valid_q || pop);

  always_comb begin
    valid_d = valid_q;
    if (rec_take_o) begin
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      yaw_q   <= angle_of(rec_i.yaw_hi, rec_i.yaw_lo);
      roll_q  <= angle_of(rec_i.roll_hi, rec_i.roll_lo);
      pitch_q <= angle_of(rec_i.pitch_hi, rec_i.pitch_lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign yaw_centi_o   = yaw_q;
  assign roll_centi_o  = roll_q;
  assign pitch_centi_o = pitch_q;

endmodule

// ===== rtl/attitude_report_deframer.sv =====
// ----------------------------------------------------------------------------
// attitude_report_deframer: attitude report deframer top level
// Recovers attitude reports from a received serial byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock and delivers one result beat
// with yaw, roll and pitch in hundredths of a degree for every completed
// frame whose code and subcode match the two configuration registers. A
// byte is accepted every cycle while full is low. The record queue takes the
// record at the edge that accepts the byte completing its frame, and the
// output register loads it from the queue once the register is empty or
// being popped. full rises only once the two-entry queue and the output
// register all hold results that have not been popped.
module attitude_report_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ard_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [ard_pkg::AngleW-1:0] yaw_centi_o,
  output logic signed [ard_pkg::AngleW-1:0] roll_centi_o,
  output logic signed [ard_pkg::AngleW-1:0] pitch_centi_o
);
  import ard_pkg::*;

  logic [7:0] code_q, sub_q;
  logic       cfg_wr;
  logic       take;
  logic       rec_valid, q_pop;
  ard_raw_t   rec, q_head;
  ard_qstat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= CodeReset;
      sub_q  <= SubcodeReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegCode) begin
        code_q <= pwdata[7:0];
      end else begin
        sub_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      RegCode:    prdata = {24'h0, code_q};
      RegSubcode: prdata = {24'h0, sub_q};
      default:    prdata = '0;
    endcase
  end

  assign full = q_stat.full;
  assign take = push && !full;

  ard_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .rx_byte_i        (rx_byte_i),
    .report_code_i    (code_q),
    .report_subcode_i (sub_q),
    .rec_valid_o      (rec_valid),
    .rec_o            (rec)
  );

  ard_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_valid),
    .wr_data_i (rec),
    .rd_i      (q_pop),
    .rd_data_o (q_head),
    .stat_o    (q_stat)
  );

  ard_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_avail_i   (!q_stat.empty),
    .rec_i         (q_head),
    .rec_take_o    (q_pop),
    .pop           (pop),
    .empty         (empty),
    .yaw_centi_o   (yaw_centi_o),
    .roll_centi_o  (roll_centi_o),
    .pitch_centi_o (pitch_centi_o)
  );

  // The queue never holds more records than it has entries.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCntW'(QDepth))
    else $error("record queue over its depth");

  // A record is only produced while the queue has room for it.
  a_no_lost_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_valid && q_stat.full))
    else $error("record produced while queue full");

  // The output register is reloaded only when its beat is gone or leaving.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (empty || pop))
    else $error("output register overwritten");

  // A queue entry taken by the angle stage shows up as a result beat.
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !empty)
    else $error("taken record did not reach the output");

endmodule
